FILE: rtl/krt_pkg.sv
// Shared constants, command codes and store control type for the keyed rule table.
package krt_pkg;

    localparam int SLOTS_DEF     = 16;
    localparam int BODY_BITS_DEF = 32;

    localparam int FUNC_W = 2;
    localparam int KEY_W  = 8;
    localparam int BODY_W = 32;
    localparam int POS_W  = 8;
    localparam int OCC_W  = 5;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOOKUP = 2'd0,
        FUNC_UPSERT = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_NTH    = 2'd3
    } func_t;

    // Write request toward the slot store: fill writes key and body, else clear.
    typedef struct packed {
        logic en;
        logic fill;
    } wr_ctl_t;

endpackage

FILE: rtl/krt_if.sv
// Command and response channel interfaces of the keyed rule table.
interface krt_cmd_if;
    logic                      valid;
    logic                      ready;
    logic [krt_pkg::FUNC_W-1:0] func;
    logic [krt_pkg::KEY_W-1:0]  rule_id;
    logic [krt_pkg::BODY_W-1:0] rule_body;
    logic [krt_pkg::POS_W-1:0]  position;

    modport source (output valid, output func, output rule_id, output rule_body,
                    output position, input ready);
    modport sink   (input valid, input func, input rule_id, input rule_body,
                    input position, output ready);
endinterface

interface krt_rsp_if;
    logic                      valid;
    logic                      ready;
    logic                      success;
    logic [krt_pkg::KEY_W-1:0]  found_id;
    logic [krt_pkg::BODY_W-1:0] found_body;
    logic [krt_pkg::OCC_W-1:0]  occupied;

    modport source (output valid, output success, output found_id, output found_body,
                    output occupied, input ready);
    modport sink   (input valid, input success, input found_id, input found_body,
                    input occupied, output ready);
endinterface

FILE: rtl/krt_store.sv
// Slot store: key and body memories, per-slot valid bits and occupied counter.
module krt_store #(
    parameter int SLOTS     = krt_pkg::SLOTS_DEF,
    parameter int BODY_BITS = krt_pkg::BODY_BITS_DEF,
    parameter int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    parameter int CNT_W     = $clog2(SLOTS + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_en,
    input  logic [IDX_W-1:0]          rd_addr,
    output logic                      rd_valid,
    output logic [krt_pkg::KEY_W-1:0] rd_key,
    output logic [BODY_BITS-1:0]      rd_body,
    input  krt_pkg::wr_ctl_t          wr,
    input  logic [IDX_W-1:0]          wr_addr,
    input  logic [krt_pkg::KEY_W-1:0] wr_key,
    input  logic [BODY_BITS-1:0]      wr_body,
    output logic [CNT_W-1:0]          count
);

    logic [krt_pkg::KEY_W-1:0] key_mem  [SLOTS];
    logic [BODY_BITS-1:0]      body_mem [SLOTS];
    logic [SLOTS-1:0]          valid_reg;
    logic [SLOTS-1:0]          valid_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      rd_valid_reg;

    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        if (wr.en)
        begin
            valid_next[wr_addr] = wr.fill;
            if (wr.fill && !valid_reg[wr_addr])
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else if (!wr.fill && valid_reg[wr_addr])
            begin
                count_next = count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // Memory ports: one write, one registered read.
    always_ff @(posedge clk)
    begin
        if (wr.en && wr.fill)
        begin
            key_mem[wr_addr]  <= wr_key;
            body_mem[wr_addr] <= wr_body;
        end
        if (rd_en)
        begin
            rd_key  <= key_mem[rd_addr];
            rd_body <= body_mem[rd_addr];
        end
    end

    assign rd_valid = rd_valid_reg;
    assign count    = count_reg;

endmodule

FILE: rtl/keyed_rule_table_top.sv
// Keyed rule table: lookup, upsert, remove and nth-occupied over a scanned slot store.
// Timing: a full scan reads every slot before the result; a key or rank hit ends the
//   scan early; a key-zero command (other than nth) answers in the cycle after accept.
// Throughput: one command at a time; the slot scan reads one slot per cycle from the
//   store's single read port.
// Reset: asynchronous, active low; clears all slot valid bits and the occupied count.
module keyed_rule_table_top #(
    parameter int SLOTS     = krt_pkg::SLOTS_DEF,
    parameter int BODY_BITS = krt_pkg::BODY_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    krt_cmd_if.sink   cmd,
    krt_rsp_if.source rsp
);

    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int KEY_W  = krt_pkg::KEY_W;
    localparam int POS_W  = krt_pkg::POS_W;
    localparam int OUT_BW = krt_pkg::BODY_W;
    localparam int OCC_W  = krt_pkg::OCC_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    state_t                 state_reg, state_next;
    krt_pkg::func_t         func_reg, func_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [BODY_BITS-1:0]   body_reg, body_next;
    logic [POS_W-1:0]       rank_reg, rank_next;
    logic [CNT_W-1:0]       iss_reg, iss_next;
    logic                   pend_reg, pend_next;
    logic [IDX_W-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                   empty_found_reg, empty_found_next;
    logic [IDX_W-1:0]       empty_idx_reg, empty_idx_next;
    logic                   success_reg, success_next;
    logic [KEY_W-1:0]       found_id_reg, found_id_next;
    logic [OUT_BW-1:0]      found_body_reg, found_body_next;

    logic                   rd_en;
    logic                   rd_valid;
    logic [KEY_W-1:0]       rd_key;
    logic [BODY_BITS-1:0]   rd_body;
    krt_pkg::wr_ctl_t       wr;
    logic [IDX_W-1:0]       wr_addr;
    logic [CNT_W-1:0]       count;

    logic                   accept;
    logic                   hit;
    logic                   last;
    logic                   done;
    logic                   empty_avail;
    logic                   is_read_cmd;

    krt_store #(
        .SLOTS     (SLOTS),
        .BODY_BITS (BODY_BITS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (iss_reg[IDX_W-1:0]),
        .rd_valid (rd_valid),
        .rd_key   (rd_key),
        .rd_body  (rd_body),
        .wr       (wr),
        .wr_addr  (wr_addr),
        .wr_key   (key_reg),
        .wr_body  (body_reg),
        .count    (count)
    );

    assign accept      = cmd.valid && cmd.ready;
    assign is_read_cmd = (func_reg == krt_pkg::FUNC_LOOKUP) || (func_reg == krt_pkg::FUNC_NTH);
    assign last        = (cmp_idx_reg == IDX_W'(SLOTS - 1));

    // Compare stage: judge the slot read in the previous cycle.
    always_comb
    begin
        hit = 1'b0;
        if (state_reg == ST_SCAN && pend_reg && rd_valid)
        begin
            if (func_reg == krt_pkg::FUNC_NTH)
            begin
                hit = (rank_reg == '0);
            end
            else
            begin
                hit = (rd_key == key_reg);
            end
        end
    end

    assign done        = (state_reg == ST_SCAN) && pend_reg && (hit || last);
    assign empty_avail = empty_found_reg || (pend_reg && !rd_valid);
    assign rd_en       = (state_reg == ST_SCAN) && (iss_reg < CNT_W'(SLOTS)) && !done;

    always_comb
    begin
        wr      = '{en: 1'b0, fill: 1'b0};
        wr_addr = cmp_idx_reg;
        if (done)
        begin
            if (func_reg == krt_pkg::FUNC_UPSERT)
            begin
                wr.fill = 1'b1;
                wr.en   = hit || empty_avail;
                if (!hit && empty_found_reg)
                begin
                    wr_addr = empty_idx_reg;
                end
            end
            else if (func_reg == krt_pkg::FUNC_REMOVE)
            begin
                wr.en = hit;
            end
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        func_next        = func_reg;
        key_next         = key_reg;
        body_next        = body_reg;
        rank_next        = rank_reg;
        iss_next         = iss_reg;
        pend_next        = pend_reg;
        cmp_idx_next     = cmp_idx_reg;
        empty_found_next = empty_found_reg;
        empty_idx_next   = empty_idx_reg;
        success_next     = success_reg;
        found_id_next    = found_id_reg;
        found_body_next  = found_body_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    func_next        = krt_pkg::func_t'(cmd.func);
                    key_next         = cmd.rule_id;
                    body_next        = BODY_BITS'(cmd.rule_body);
                    rank_next        = cmd.position;
                    iss_next         = '0;
                    pend_next        = 1'b0;
                    empty_found_next = 1'b0;
                    success_next     = 1'b0;
                    found_id_next    = '0;
                    found_body_next  = '0;
                    // Key zero fails at once, except for nth which ignores the key.
                    if (cmd.rule_id == '0 && krt_pkg::func_t'(cmd.func) != krt_pkg::FUNC_NTH)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                pend_next = rd_en;
                if (rd_en)
                begin
                    iss_next     = iss_reg + CNT_W'(1);
                    cmp_idx_next = iss_reg[IDX_W-1:0];
                end
                if (pend_reg)
                begin
                    if (!rd_valid && !empty_found_reg)
                    begin
                        empty_found_next = 1'b1;
                        empty_idx_next   = cmp_idx_reg;
                    end
                    if (func_reg == krt_pkg::FUNC_NTH && rd_valid && !hit)
                    begin
                        rank_next = rank_reg - POS_W'(1);
                    end
                end
                if (done)
                begin
                    state_next = ST_OUT;
                    if (func_reg == krt_pkg::FUNC_UPSERT)
                    begin
                        success_next = hit || empty_avail;
                    end
                    else
                    begin
                        success_next = hit;
                    end
                    if (hit && is_read_cmd)
                    begin
                        found_id_next   = rd_key;
                        found_body_next = OUT_BW'(rd_body);
                    end
                end
            end
            ST_OUT:
            begin
                if (rsp.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            iss_reg         <= '0;
            pend_reg        <= 1'b0;
            empty_found_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            iss_reg         <= iss_next;
            pend_reg        <= pend_next;
            empty_found_reg <= empty_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        key_reg        <= key_next;
        body_reg       <= body_next;
        rank_reg       <= rank_next;
        cmp_idx_reg    <= cmp_idx_next;
        empty_idx_reg  <= empty_idx_next;
        success_reg    <= success_next;
        found_id_reg   <= found_id_next;
        found_body_reg <= found_body_next;
    end

    assign cmd.ready      = (state_reg == ST_IDLE);
    assign rsp.valid      = (state_reg == ST_OUT);
    assign rsp.success    = success_reg;
    assign rsp.found_id   = found_id_reg;
    assign rsp.found_body = found_body_reg;
    assign rsp.occupied   = OCC_W'(count);

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.ready && rsp.valid))
        else $error("command taken while a result is pending");

    a_id_needs_success: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.found_id != '0) |-> rsp.success)
        else $error("returned entry on a failed command");

    a_write_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (state_reg == ST_SCAN) && (func_reg != krt_pkg::FUNC_LOOKUP)
                  && (func_reg != krt_pkg::FUNC_NTH))
        else $error("store write outside an upsert or remove scan");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CNT_W'(SLOTS))
        else $error("occupied count exceeds slot count");

    a_count_steady: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && $past(rsp.valid) |-> $stable(count))
        else $error("occupied count moved while result is held");

endmodule
